// ----- rtl/core/timer_expiry_priority_queue_macros.svh -----
// Assertion macros for the timer expiry priority queue.
`ifndef TIMER_EXPIRY_PRIORITY_QUEUE_MACROS_SVH
`define TIMER_EXPIRY_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TEPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// Next-cycle implication, disabled in reset.
`define TEPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

// ----- rtl/core/tepq_pkg.sv -----
// Types and codes shared by the timer expiry priority queue.
package tepq_pkg;

  // Command codes
  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_UPDATE = 3'd1;
  localparam logic [2:0] MODE_STOP   = 3'd2;
  localparam logic [2:0] MODE_TICK   = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_ERROR   = 2'd1;
  localparam logic [1:0] ST_EXPIRED = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  timer_id;
    logic [31:0] time_value;
  } tepq_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] expired_id;
  } tepq_out_t;

endpackage

// ----- rtl/core/timer_expiry_priority_queue.sv -----
// Top level of the timer expiry priority queue.
// Start, update, stop and clear strobe their result in the cycle after the
// transfer and busy stays low. A tick walks the expiry memory one entry per
// cycle to find the earliest active timer (ties to the lowest id); it holds
// busy until the last entry has been compared, and its result strobes as
// busy falls. The receiver cannot stall: every result is shown for exactly
// one cycle on out_valid.
`include "timer_expiry_priority_queue_macros.svh"
module timer_expiry_priority_queue
  import tepq_pkg::*;
#(
  parameter int MAX_TIMERS = 64,
  parameter int TIME_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  tepq_in_t  in_payload,
  output logic      out_valid,
  output tepq_out_t out_payload
);

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TIMERS - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [TIME_WIDTH-1:0] mem [MAX_TIMERS];
  logic [TIME_WIDTH-1:0] rd_data_r;
  logic [IW-1:0]         rd_addr;
  logic [MAX_TIMERS-1:0] active_r, active_nxt;
  logic [IW-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                  found_r, found_nxt;
  logic [IW-1:0]         best_r, best_nxt;
  logic [TIME_WIDTH-1:0] best_t_r, best_t_nxt;
  logic [TIME_WIDTH-1:0] now_r, now_nxt;
  logic                  out_valid_r, out_valid_nxt;
  tepq_out_t             out_r, out_nxt;

  logic                  accept;
  logic [IW-1:0]         idx;
  logic [TIME_WIDTH-1:0] t_in;
  logic                  id_ok;
  logic                  wr_en;
  logic                  take;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign idx    = IW'(in_payload.timer_id);
  assign t_in   = TIME_WIDTH'(in_payload.time_value);
  assign id_ok  = (32'(in_payload.timer_id) < 32'(MAX_TIMERS));

  // Expiry written by start and by a valid update
  assign wr_en = accept && id_ok &&
                 ((in_payload.mode == MODE_START) ||
                  ((in_payload.mode == MODE_UPDATE) && active_r[idx] && (t_in != '0)));

  // Next read: entry 0 on a tick transfer, then one entry ahead per cycle
  assign rd_addr = (state_r == S_IDLE) ? '0 : cmp_idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= t_in;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Candidate test for the entry whose data has just come back
  assign take = active_r[cmp_idx_r] && (!found_r || (rd_data_r < best_t_r));

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_t_nxt    = best_t_r;
    now_nxt       = now_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.status     = ST_ERROR;
          out_nxt.expired_id = '0;
          case (in_payload.mode)
            MODE_START: begin
              if (id_ok) begin
                active_nxt[idx] = 1'b1;
                out_nxt.status  = ST_DONE;
              end
            end
            MODE_UPDATE: begin
              if (wr_en) out_nxt.status = ST_DONE;
            end
            MODE_STOP: begin
              if (id_ok && active_r[idx]) begin
                active_nxt[idx] = 1'b0;
                out_nxt.status  = ST_DONE;
              end
            end
            MODE_CLEAR: begin
              active_nxt     = '0;
              out_nxt.status = ST_DONE;
            end
            default: ;
          endcase
          if (in_payload.mode == MODE_TICK) begin
            state_nxt   = S_SCAN;
            cmp_idx_nxt = '0;
            found_nxt   = 1'b0;
            now_nxt     = t_in;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (take) begin
          found_nxt  = 1'b1;
          best_nxt   = cmp_idx_r;
          best_t_nxt = rd_data_r;
        end
        if (cmp_idx_r == LAST_IDX) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if ((take || found_r) && (best_t_nxt <= now_r)) begin
            active_nxt[best_nxt] = 1'b0;
            out_nxt.status       = ST_EXPIRED;
            out_nxt.expired_id   = 6'(best_nxt);
          end else begin
            out_nxt.status     = ST_NONE;
            out_nxt.expired_id = '0;
          end
        end else begin
          cmp_idx_nxt = cmp_idx_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan and result payload
  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    found_r   <= found_nxt;
    best_r    <= best_nxt;
    best_t_r  <= best_t_nxt;
    now_r     <= now_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  `TEPQ_ASSERT_NEXT(a_quick_result, clk, rst_n, accept && (in_payload.mode != MODE_TICK), out_valid)
  `TEPQ_ASSERT_NOW(a_no_result_in_scan, clk, rst_n, state_r == S_SCAN, !out_valid)
  `TEPQ_ASSERT_NOW(a_expired_after_scan, clk, rst_n, out_valid && (out_r.status == ST_EXPIRED), $past(state_r == S_SCAN))
  `TEPQ_ASSERT_NEXT(a_expired_cleared, clk, rst_n, (state_r == S_SCAN) && (state_nxt == S_IDLE) && (out_nxt.status == ST_EXPIRED), !active_r[$past(best_nxt)])

endmodule
